// ===== src/tsa_pkg.sv =====
// tsa_pkg: shared types and constants of the tile atlas square allocator
// no dependencies; imported by tsa_div, the allocator unit, the checker and the bench
package tsa_pkg;

    localparam int DIM_W  = 15;   // atlas width and height
    localparam int TS_W   = 13;   // tile edge
    localparam int EDGE_W = 16;   // requested edge
    localparam int ID_W   = 31;   // slot id
    localparam int POS_W  = 14;   // region position
    localparam int NUM_W  = 17;   // dividend of the ceiling divisions
    localparam int CFG_W  = 2;    // register index

    localparam logic [CFG_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0] CFG_TILE_SIZE    = 2'd2;

    localparam logic [DIM_W-1:0] ATLAS_RESET = 15'd4096;
    localparam logic [TS_W-1:0]  TILE_RESET  = 13'd256;

    typedef enum logic [2:0] {
        ST_ALLOC      = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_FREED      = 3'd3,
        ST_UNKNOWN    = 3'd4
    } tsa_status_t;

    typedef struct packed {
        logic              action;
        logic [EDGE_W-1:0] edge_px;
        logic [ID_W-1:0]   free_slot_id;
    } tsa_in_t;

    typedef struct packed {
        tsa_status_t       status;
        logic [ID_W-1:0]   slot_id;
        logic [POS_W-1:0]  region_x;
        logic [POS_W-1:0]  region_y;
        logic [DIM_W-1:0]  region_width;
        logic [DIM_W-1:0]  region_height;
    } tsa_out_t;

endpackage

// ===== src/tsa_ram.sv =====
// tsa_ram: generic single-port synchronous ram with registered read
// no dependencies
module tsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tsa_div.sv =====
// tsa_div: restoring divider, one quotient bit per cycle
// depends on tsa_pkg
module tsa_div import tsa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [TS_W-1:0]  den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [TS_W:0]    r_reg, r_next;
    logic [TS_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [TS_W:0]    r_shift;
    logic             ge;

    assign r_shift = {r_reg[TS_W-1:0], q_reg[NUM_W-1]};
    assign ge      = r_shift >= {1'b0, d_reg};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            r_next   = ge ? (r_shift - {1'b0, d_reg}) : r_shift;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== src/tile_atlas_square_allocator_unit.sv =====
// tile_atlas_square_allocator_unit: first-fit square allocator over a tile grid
// depends on tsa_pkg, tsa_ram, tsa_div
//
//  channel   ports                          transaction
//  config    cfg_we cfg_index cfg_wdata     register write, clears the atlas
//  input     s_valid s_ready s_data         allocate or free request
//  output    m_valid m_ready m_data         one result per request
//
// one request at a time; the output register lets the next request in while
// a result still waits
// free: the slot table scan, then a read and a write of each of the span rows
// to clear their bits
// allocate: 3 divisions (tiles across, tiles down, span), the slot scan, then
// per candidate row the span row reads and a column walk, then a read and a write
// of each span row to mark it, then region math in S_MATH1 and S_MATH2
// reset and every write to one of the three registers start a clearing pass
// over both memories during which s_ready stays low
module tile_atlas_square_allocator_unit import tsa_pkg::*; #(
    parameter int MAX_TILES_X = 32,
    parameter int MAX_TILES_Y = 32,
    parameter int MAX_SLOTS   = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  tsa_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tsa_out_t         m_data
);

    // widths that follow from the grid and table limits
    localparam int CX_W      = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
    localparam int CY_W      = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int TX_W      = $clog2(MAX_TILES_X + 1);
    localparam int TY_W      = $clog2(MAX_TILES_Y + 1);
    localparam int MIN_TILES = (MAX_TILES_X < MAX_TILES_Y) ? MAX_TILES_X : MAX_TILES_Y;
    localparam int SPAN_W    = $clog2(MIN_TILES + 1);
    localparam int CLR_DEPTH = (MAX_TILES_Y > MAX_SLOTS) ? MAX_TILES_Y : MAX_SLOTS;
    localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int MAXC_W    = (CX_W > CY_W) ? ((CX_W > SPAN_W) ? CX_W : SPAN_W)
                                             : ((CY_W > SPAN_W) ? CY_W : SPAN_W);
    localparam int PW        = MAXC_W + TS_W + 1;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [CX_W-1:0]   cx;
        logic [CY_W-1:0]   cy;
        logic [SPAN_W-1:0] span;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_DIV_TX    = 13'b0000000000100,
        S_DIV_TY    = 13'b0000000001000,
        S_DIV_SP    = 13'b0000000010000,
        S_SLOT_SCAN = 13'b0000000100000,
        S_ROW_RD    = 13'b0000001000000,
        S_COL       = 13'b0000010000000,
        S_MARK_RD   = 13'b0000100000000,
        S_MARK_WR   = 13'b0001000000000,
        S_MATH1     = 13'b0010000000000,
        S_MATH2     = 13'b0100000000000,
        S_RESULT    = 13'b1000000000000
    } state_t;

    // control state
    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  aw_reg, aw_next;
    logic [DIM_W-1:0]  ah_reg, ah_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic              m_valid_reg, m_valid_next;

    // working registers of one transaction
    tsa_in_t           req_reg, req_next;
    tsa_out_t          res_reg, res_next;
    tsa_out_t          m_data_reg, m_data_next;
    logic [TX_W-1:0]   tx_reg, tx_next;
    logic [TY_W-1:0]   ty_reg, ty_next;
    logic [NUM_W-1:0]  sp_reg, sp_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic [SLOT_W-1:0] slot_idx_reg, slot_idx_next;
    logic [SLOT_W-1:0] scan_addr_reg, scan_addr_next;
    logic [SLOT_W-1:0] scan_prev_reg, scan_prev_next;
    logic              scan_pend_reg, scan_pend_next;
    logic [CX_W-1:0]   cx_reg, cx_next;
    logic [CY_W-1:0]   cy_reg, cy_next;
    logic [CX_W-1:0]   col_reg, col_next;
    logic [SPAN_W-1:0] run_reg, run_next;
    logic [SPAN_W-1:0] rcnt_reg, rcnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [MAX_TILES_X-1:0] acc_reg, acc_next;
    logic [SPAN_W-1:0] mrow_reg, mrow_next;
    logic [PW-1:0]     x_reg, x_next;
    logic [PW-1:0]     y_reg, y_next;
    logic [PW-1:0]     w_reg, w_next;

    // memory ports
    logic                   tile_we;
    logic [CY_W-1:0]        tile_addr;
    logic [MAX_TILES_X-1:0] tile_wdata, tile_rdata;
    logic                   slot_we;
    logic [SLOT_W-1:0]      slot_addr;
    slot_t                  slot_wdata, slot_rdata;
    logic [SLOT_BITS-1:0]   slot_rbits;

    // divider
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_q;

    // derived operands, zero taken as one
    logic [DIM_W-1:0]       aw_eff, ah_eff;
    logic [TS_W-1:0]        ts_eff;
    logic [EDGE_W-1:0]      edge_eff;
    logic [MAX_TILES_X-1:0] span_mask;
    logic                   is_free;
    logic                   slot_hit;
    logic                   col_free;
    logic [PW-1:0]          w_clip, h_clip;

    assign aw_eff   = (aw_reg == '0) ? DIM_W'(1) : aw_reg;
    assign ah_eff   = (ah_reg == '0) ? DIM_W'(1) : ah_reg;
    assign ts_eff   = (ts_reg == '0) ? TS_W'(1) : ts_reg;
    assign edge_eff = (req_reg.edge_px == '0) ? EDGE_W'(1) : req_reg.edge_px;
    assign is_free  = req_reg.action;
    assign slot_rdata = slot_t'(slot_rbits);

    // tiles cx .. cx+span-1 of a row
    always_comb begin
        for (int i = 0; i < MAX_TILES_X; i++) begin
            span_mask[i] = (i >= int'(cx_reg)) && (i < int'(cx_reg) + int'(span_reg));
        end
    end

    // first invalid entry for allocate, first valid id match for free
    assign slot_hit = is_free ? (slot_rdata.valid && slot_rdata.id == req_reg.free_slot_id)
                              : !slot_rdata.valid;
    assign col_free = !acc_reg[col_reg];

    // clip the region against the atlas edges
    assign w_clip = (x_reg + w_reg > PW'(aw_eff)) ? (PW'(aw_eff) - x_reg) : w_reg;
    assign h_clip = (y_reg + w_reg > PW'(ah_eff)) ? (PW'(ah_eff) - y_reg) : w_reg;

    assign s_ready = (state_reg == S_IDLE) && !cfg_we;

    always_comb begin
        state_next     = state_reg;
        aw_next        = aw_reg;
        ah_next        = ah_reg;
        ts_next        = ts_reg;
        next_id_next   = next_id_reg;
        clr_next       = clr_reg;
        m_valid_next   = m_valid_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        sp_next        = sp_reg;
        span_next      = span_reg;
        slot_idx_next  = slot_idx_reg;
        scan_addr_next = scan_addr_reg;
        scan_prev_next = scan_prev_reg;
        scan_pend_next = scan_pend_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        col_next       = col_reg;
        run_next       = run_reg;
        rcnt_next      = rcnt_reg;
        rd_pend_next   = rd_pend_reg;
        acc_next       = acc_reg;
        mrow_next      = mrow_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        tile_we        = 1'b0;
        tile_addr      = '0;
        tile_wdata     = '0;
        slot_we        = 1'b0;
        slot_addr      = '0;
        slot_wdata     = '0;
        div_start      = 1'b0;
        div_num        = NUM_W'(aw_eff) + NUM_W'(ts_eff) - NUM_W'(1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // zero both memories, one address a cycle
                tile_we      = int'(clr_reg) < MAX_TILES_Y;
                tile_addr    = clr_reg[CY_W-1:0];
                slot_we      = int'(clr_reg) < MAX_SLOTS;
                slot_addr    = clr_reg[SLOT_W-1:0];
                next_id_next = '0;
                if (int'(clr_reg) == CLR_DEPTH - 1) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next       = s_data;
                    res_next       = '0;
                    scan_addr_next = '0;
                    scan_pend_next = 1'b0;
                    if (s_data.action) begin
                        state_next = S_SLOT_SCAN;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV_TX;
                    end
                end
            end
            S_DIV_TX: begin
                div_num = NUM_W'(ah_eff) + NUM_W'(ts_eff) - NUM_W'(1);
                if (div_done) begin
                    tx_next    = (int'(div_q) > MAX_TILES_X) ? TX_W'(MAX_TILES_X)
                                                             : div_q[TX_W-1:0];
                    div_start  = 1'b1;
                    state_next = S_DIV_TY;
                end
            end
            S_DIV_TY: begin
                div_num = NUM_W'(edge_eff) + NUM_W'(ts_eff) - NUM_W'(1);
                if (div_done) begin
                    ty_next    = (int'(div_q) > MAX_TILES_Y) ? TY_W'(MAX_TILES_Y)
                                                             : div_q[TY_W-1:0];
                    div_start  = 1'b1;
                    state_next = S_DIV_SP;
                end
            end
            S_DIV_SP: begin
                if (div_done) begin
                    sp_next    = div_q;
                    state_next = S_SLOT_SCAN;
                end
            end
            S_SLOT_SCAN: begin
                // one read a cycle, its data checked in the cycle after
                slot_addr      = scan_addr_reg;
                scan_pend_next = 1'b1;
                scan_prev_next = scan_addr_reg;
                if (int'(scan_addr_reg) != MAX_SLOTS - 1) begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (scan_pend_reg && slot_hit) begin
                    slot_idx_next = scan_prev_reg;
                    if (is_free) begin
                        cx_next    = slot_rdata.cx;
                        cy_next    = slot_rdata.cy;
                        span_next  = slot_rdata.span;
                        mrow_next  = '0;
                        state_next = S_MARK_RD;
                    end else if (int'(sp_reg) > int'(tx_reg) || int'(sp_reg) > int'(ty_reg)) begin
                        res_next.status = ST_NO_SPACE;
                        state_next      = S_RESULT;
                    end else begin
                        span_next    = sp_reg[SPAN_W-1:0];
                        cy_next      = '0;
                        rcnt_next    = '0;
                        rd_pend_next = 1'b0;
                        acc_next     = '0;
                        state_next   = S_ROW_RD;
                    end
                end else if (scan_pend_reg && int'(scan_prev_reg) == MAX_SLOTS - 1) begin
                    res_next.status = is_free ? ST_UNKNOWN : ST_TABLE_FULL;
                    state_next      = S_RESULT;
                end
            end
            S_ROW_RD: begin
                // OR the span rows of this candidate band into one busy row
                tile_addr = CY_W'(int'(cy_reg) + int'(rcnt_reg));
                if (int'(rcnt_reg) < int'(span_reg)) begin
                    rcnt_next    = rcnt_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                end
                if (rd_pend_reg) begin
                    acc_next = acc_reg | tile_rdata;
                end
                if (rcnt_reg == span_reg && !rd_pend_reg) begin
                    col_next   = '0;
                    run_next   = '0;
                    state_next = S_COL;
                end
            end
            S_COL: begin
                // count free columns until a run of span
                if (col_free && int'(run_reg) + 1 == int'(span_reg)) begin
                    cx_next    = CX_W'(int'(col_reg) - int'(span_reg) + 1);
                    mrow_next  = '0;
                    state_next = S_MARK_RD;
                end else if (int'(col_reg) + 1 == int'(tx_reg)) begin
                    if (int'(cy_reg) + 1 + int'(span_reg) > int'(ty_reg)) begin
                        res_next.status = ST_NO_SPACE;
                        state_next      = S_RESULT;
                    end else begin
                        cy_next      = cy_reg + 1'b1;
                        rcnt_next    = '0;
                        rd_pend_next = 1'b0;
                        acc_next     = '0;
                        state_next   = S_ROW_RD;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                    run_next = col_free ? (run_reg + 1'b1) : '0;
                end
            end
            S_MARK_RD: begin
                tile_addr  = CY_W'(int'(cy_reg) + int'(mrow_reg));
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                tile_addr  = CY_W'(int'(cy_reg) + int'(mrow_reg));
                tile_we    = 1'b1;
                tile_wdata = is_free ? (tile_rdata & ~span_mask) : (tile_rdata | span_mask);
                if (int'(mrow_reg) + 1 == int'(span_reg)) begin
                    slot_we   = 1'b1;
                    slot_addr = slot_idx_reg;
                    if (is_free) begin
                        slot_wdata      = '0;
                        res_next.status = ST_FREED;
                        state_next      = S_RESULT;
                    end else begin
                        slot_wdata.valid = 1'b1;
                        slot_wdata.id    = next_id_reg;
                        slot_wdata.cx    = cx_reg;
                        slot_wdata.cy    = cy_reg;
                        slot_wdata.span  = span_reg;
                        res_next.status  = ST_ALLOC;
                        res_next.slot_id = next_id_reg;
                        next_id_next     = next_id_reg + 1'b1;
                        state_next       = S_MATH1;
                    end
                end else begin
                    mrow_next  = mrow_reg + 1'b1;
                    state_next = S_MARK_RD;
                end
            end
            S_MATH1: begin
                x_next     = PW'(cx_reg) * PW'(ts_eff);
                y_next     = PW'(cy_reg) * PW'(ts_eff);
                w_next     = PW'(span_reg) * PW'(ts_eff);
                state_next = S_MATH2;
            end
            S_MATH2: begin
                res_next.region_x      = x_reg[POS_W-1:0];
                res_next.region_y      = y_reg[POS_W-1:0];
                res_next.region_width  = w_clip[DIM_W-1:0];
                res_next.region_height = h_clip[DIM_W-1:0];
                state_next             = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        // a write to one of the three registers re-initializes the atlas
        if (cfg_we && (cfg_index == CFG_ATLAS_WIDTH || cfg_index == CFG_ATLAS_HEIGHT ||
                       cfg_index == CFG_TILE_SIZE)) begin
            unique case (cfg_index)
                CFG_ATLAS_WIDTH:  aw_next = cfg_wdata;
                CFG_ATLAS_HEIGHT: ah_next = cfg_wdata;
                CFG_TILE_SIZE:    ts_next = cfg_wdata[TS_W-1:0];
                default:          ts_next = ts_reg;
            endcase
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            aw_reg      <= ATLAS_RESET;
            ah_reg      <= ATLAS_RESET;
            ts_reg      <= TILE_RESET;
            next_id_reg <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            aw_reg      <= aw_next;
            ah_reg      <= ah_next;
            ts_reg      <= ts_next;
            next_id_reg <= next_id_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        sp_reg        <= sp_next;
        span_reg      <= span_next;
        slot_idx_reg  <= slot_idx_next;
        scan_addr_reg <= scan_addr_next;
        scan_prev_reg <= scan_prev_next;
        scan_pend_reg <= scan_pend_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        col_reg       <= col_next;
        run_reg       <= run_next;
        rcnt_reg      <= rcnt_next;
        rd_pend_reg   <= rd_pend_next;
        acc_reg       <= acc_next;
        mrow_reg      <= mrow_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        w_reg         <= w_next;
    end

    // one busy row per grid row
    tsa_ram #(
        .WIDTH (MAX_TILES_X),
        .DEPTH (MAX_TILES_Y)
    ) u_tile_ram (
        .aclk  (aclk),
        .we    (tile_we),
        .addr  (tile_addr),
        .wdata (tile_wdata),
        .rdata (tile_rdata)
    );

    // slot table, valid flag stored with each entry
    tsa_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rbits)
    );

    // ceiling divisions for grid size and span
    tsa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (ts_eff),
        .done    (div_done),
        .quot    (div_q)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/tsa_checker.sv =====
// tsa_checker: port-level checks of the allocator, bound to the top level
// depends on tsa_pkg and tile_atlas_square_allocator_unit
module tsa_checker import tsa_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             cfg_we,
    input logic [CFG_W-1:0] cfg_index,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input tsa_out_t         m_data
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in flight");

    // the clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during clearing pass");

    // a register write starts a clearing pass
    a_clear_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index == CFG_ATLAS_WIDTH || cfg_index == CFG_ATLAS_HEIGHT ||
                   cfg_index == CFG_TILE_SIZE) |=> !s_ready)
        else $error("ready right after a register write");

    // only an allocation carries id and region
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_ALLOC |->
            m_data.slot_id == '0 && m_data.region_x == '0 && m_data.region_y == '0 &&
            m_data.region_width == '0 && m_data.region_height == '0)
        else $error("fields set on a result that is not an allocation");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind tile_atlas_square_allocator_unit tsa_checker u_tsa_checker (.*);

// ===== tb/tile_atlas_square_allocator_unit_tb.sv =====
// tile_atlas_square_allocator_unit_tb: self-checking bench of the square allocator
// depends on tsa_pkg and tile_atlas_square_allocator_unit; a small scoreboard class
// mirrors the tile grid and slot table and checks each result in order
`timescale 1ns / 1ps

module tile_atlas_square_allocator_unit_tb;
    import tsa_pkg::*;

    localparam int GX = 32;
    localparam int GY = 32;
    localparam int NSLOT = 64;
    localparam int WATCHDOG = 200000;

    // scoreboard: own copy of config, occupancy, slots; queue of expected results
    class alloc_scoreboard;
        logic [DIM_W-1:0] aw_reg, ah_reg;
        logic [TS_W-1:0]  ts_reg;
        bit               busy[GY][GX];
        bit               sv[NSLOT];
        logic [ID_W-1:0]  sid[NSLOT];
        int               scx[NSLOT], scy[NSLOT], sspan[NSLOT];
        logic [ID_W-1:0]  id_ctr;
        tsa_out_t         pending[$];
        int               errors;
        int               seen;

        function void wipe();
            foreach (busy[y, x]) busy[y][x] = 0;
            foreach (sv[i]) sv[i] = 0;
            id_ctr = '0;
        endfunction

        function void reset_all();
            aw_reg = ATLAS_RESET;
            ah_reg = ATLAS_RESET;
            ts_reg = TILE_RESET;
            errors = 0;
            seen = 0;
            wipe();
        endfunction

        function void reg_write(logic [CFG_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_ATLAS_WIDTH:  aw_reg = val;
                CFG_ATLAS_HEIGHT: ah_reg = val;
                CFG_TILE_SIZE:    ts_reg = val[TS_W-1:0];
                default: return;
            endcase
            wipe();
        endfunction

        function bit fits(int cx, int cy, int sp);
            for (int dy = 0; dy < sp; dy++)
                for (int dx = 0; dx < sp; dx++)
                    if (busy[cy+dy][cx+dx]) return 0;
            return 1;
        endfunction

        function void paint(int cx, int cy, int sp, bit v);
            for (int dy = 0; dy < sp; dy++)
                for (int dx = 0; dx < sp; dx++)
                    busy[cy+dy][cx+dx] = v;
        endfunction

        function void note_request(tsa_in_t req);
            longint aw, ah, ts, ed, tx, ty, x, y, w, h;
            int sp;
            int fidx;
            tsa_out_t r;
            r = '0;
            aw = (aw_reg == 0) ? 1 : aw_reg;
            ah = (ah_reg == 0) ? 1 : ah_reg;
            ts = (ts_reg == 0) ? 1 : ts_reg;
            ed = (req.edge_px == 0) ? 1 : req.edge_px;
            if (req.action) begin
                r.status = ST_UNKNOWN;
                for (int i = 0; i < NSLOT; i++) begin
                    if (sv[i] && sid[i] == req.free_slot_id) begin
                        paint(scx[i], scy[i], sspan[i], 0);
                        sv[i] = 0;
                        r.status = ST_FREED;
                        break;
                    end
                end
                pending.push_back(r);
                return;
            end
            tx = (aw + ts - 1) / ts; if (tx > GX) tx = GX;
            ty = (ah + ts - 1) / ts; if (ty > GY) ty = GY;
            sp = int'((ed + ts - 1) / ts);
            fidx = -1;
            for (int i = 0; i < NSLOT; i++)
                if (!sv[i]) begin fidx = i; break; end
            r.status = ST_NO_SPACE;
            if (fidx < 0) begin
                r.status = ST_TABLE_FULL;
            end else if (sp <= tx && sp <= ty) begin
                for (int cy = 0; cy + sp <= ty && r.status != ST_ALLOC; cy++) begin
                    for (int cx = 0; cx + sp <= tx; cx++) begin
                        if (!fits(cx, cy, sp)) continue;
                        paint(cx, cy, sp, 1);
                        sv[fidx] = 1; sid[fidx] = id_ctr;
                        scx[fidx] = cx; scy[fidx] = cy; sspan[fidx] = sp;
                        r.status = ST_ALLOC;
                        r.slot_id = id_ctr;
                        id_ctr = id_ctr + 1'b1;
                        x = cx * ts; y = cy * ts; w = sp * ts; h = w;
                        if (x + w > aw) w = aw - x;
                        if (y + h > ah) h = ah - y;
                        r.region_x = x[POS_W-1:0];
                        r.region_y = y[POS_W-1:0];
                        r.region_width = w[DIM_W-1:0];
                        r.region_height = h[DIM_W-1:0];
                        break;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(tsa_out_t got);
            tsa_out_t e;
            seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            if (got.slot_id !== e.slot_id)
                $display("%0t: slot_id exp %0d got %0d", $time, e.slot_id, got.slot_id);
            if (got.region_x !== e.region_x)
                $display("%0t: region_x exp %0d got %0d", $time, e.region_x, got.region_x);
            if (got.region_y !== e.region_y)
                $display("%0t: region_y exp %0d got %0d", $time, e.region_y, got.region_y);
            if (got.region_width !== e.region_width)
                $display("%0t: region_width exp %0d got %0d", $time,
                         e.region_width, got.region_width);
            if (got.region_height !== e.region_height)
                $display("%0t: region_height exp %0d got %0d", $time,
                         e.region_height, got.region_height);
            if (got !== e) errors++;
        endfunction
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             cfg_we = 0;
    logic [CFG_W-1:0] cfg_index = CFG_ATLAS_WIDTH;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic             s_valid = 0;
    logic             s_ready;
    tsa_in_t          s_data = '0;
    logic             m_valid;
    logic             m_ready = 0;
    tsa_out_t         m_data;

    alloc_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_off = 0;      // receiver long stall window
    bit  stim_done = 0;
    bit  drain_quick = 0;   // no random stall on the receiver while draining

    always #5 aclk = ~aclk;

    tile_atlas_square_allocator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // sample transactions at the rising edge; watchdog counts quiet cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("tile_atlas_square_allocator_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall per result, bursts of none, plus one long hold-off
    initial begin : receiver
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
            end else begin
                gap = ($urandom_range(0, 3) == 0 || drain_quick) ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    m_ready <= 0;
                    repeat (gap) @(negedge aclk);
                end
                m_ready <= 1;
                do @(posedge aclk); while (!(m_valid && m_ready) && !hold_off);
            end
        end
    end

    // valid stays high into the next item when there is no gap; the caller
    // of a stream drops it after the last item
    task automatic send_item(tsa_in_t item, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic do_alloc(int edge_v);
        tsa_in_t t;
        t = '0;
        t.action = 0;
        t.edge_px = edge_v[EDGE_W-1:0];
        t.free_slot_id = ID_W'($urandom());
        send_item(t, 0);
    endtask

    task automatic do_free(logic [ID_W-1:0] id_v);
        tsa_in_t t;
        t = '0;
        t.action = 1;
        t.edge_px = EDGE_W'($urandom());
        t.free_slot_id = id_v;
        send_item(t, 0);
    endtask

    // wait until every result is in, then past any leftover work
    task automatic settle();
        drain_quick = 1;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        drain_quick = 0;
    endtask

    task automatic write_reg(logic [CFG_W-1:0] idx, logic [DIM_W-1:0] val);
        settle();
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
        sb.reg_write(idx, val);
    endtask

    // pick an edge mostly of a few tiles, sometimes anything
    function automatic int rand_edge();
        int ts;
        ts = (sb.ts_reg == 0) ? 1 : sb.ts_reg;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65535);
            1: return 0;
            default: return $urandom_range(1, ts * $urandom_range(1, 4));
        endcase
    endfunction

    // free a live id most of the time, else a random one
    function automatic logic [ID_W-1:0] pick_id();
        int live[$];
        foreach (sb.sv[i]) if (sb.sv[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(0, 4) != 0)
            return sb.sid[live[$urandom_range(0, live.size() - 1)]];
        if ($urandom_range(0, 1)) return ID_W'(sb.id_ctr + $urandom_range(0, 3));
        return ID_W'($urandom());
    endfunction

    task automatic random_phase(int n, int alloc_bias);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < alloc_bias) do_alloc(rand_edge());
            else do_free(pick_id());
        end
        s_valid <= 0;
    endtask

    initial begin : stimulus
        sb = new();
        sb.reset_all();
        repeat (7) @(negedge aclk);
        aresetn <= 1;

        // directed: extremes at reset config
        do_alloc(0);
        do_alloc(65535);             // wider than grid
        do_alloc(4096);              // whole atlas
        do_alloc(1);                 // one tile, fits beside the first
        do_free(0);
        do_free(0);                  // already released
        do_free(31'h7FFFFFFF);
        do_alloc(256);
        do_alloc(257);
        do_alloc(511);

        // fill the slot table with one-tile squares until it reports full
        for (int k = 0; k < 66; k++) do_alloc(1);
        do_free(3);
        do_alloc(300);

        // long receiver stall while requests keep coming
        fork
            begin
                hold_off = 1;
                repeat (3000) @(negedge aclk);
                hold_off = 0;
            end
            random_phase(20, 60);
        join

        // atlas of 10 by 7 whole tiles of 100 px, so no region is clipped
        write_reg(CFG_ATLAS_WIDTH, 15'd1000);
        write_reg(CFG_ATLAS_HEIGHT, 15'd700);
        write_reg(CFG_TILE_SIZE, 15'd100);
        random_phase(250, 70);

        // oversized tiles: 5x5 grid, last row and column clipped, position masking
        write_reg(CFG_ATLAS_WIDTH, 15'h7FFF);
        write_reg(CFG_ATLAS_HEIGHT, 15'h7FFF);
        write_reg(CFG_TILE_SIZE, 15'd8191);
        random_phase(200, 70);

        // zero registers taken as one: one-tile atlas
        write_reg(CFG_ATLAS_WIDTH, 15'd0);
        write_reg(CFG_ATLAS_HEIGHT, 15'd0);
        write_reg(CFG_TILE_SIZE, 15'd0);
        random_phase(100, 60);

        // tiny tiles, full grid of 32x32
        write_reg(CFG_ATLAS_WIDTH, 15'd16384);
        write_reg(CFG_ATLAS_HEIGHT, 15'd16384);
        write_reg(CFG_TILE_SIZE, 15'd4);
        random_phase(350, 65);

        // unequal grid, bits of the upper register positions
        write_reg(CFG_ATLAS_WIDTH, 15'h5555);
        write_reg(CFG_ATLAS_HEIGHT, 15'h2AAA);
        write_reg(CFG_TILE_SIZE, 15'h1AAA);
        random_phase(150, 60);
        write_reg(CFG_ATLAS_WIDTH, 15'd4096);
        write_reg(CFG_ATLAS_HEIGHT, 15'd4096);
        write_reg(CFG_TILE_SIZE, 15'd4096);
        random_phase(100, 60);
        write_reg(CFG_TILE_SIZE, 15'd512);
        random_phase(280, 65);

        settle();
        stim_done = 1;
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tile_atlas_square_allocator_unit_tb: PASS");
        end else begin
            $display("tile_atlas_square_allocator_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tsa_pkg.sv
src/tsa_ram.sv
src/tsa_div.sv
src/tile_atlas_square_allocator_unit.sv
src/tsa_checker.sv
tb/tile_atlas_square_allocator_unit_tb.sv
